// File: sv/frsl_pkg.sv
package frsl_pkg;

	localparam logic [1:0] MODE_CLEAR  = 2'd0;
	localparam logic [1:0] MODE_LOAD   = 2'd1;
	localparam logic [1:0] MODE_LOOKUP = 2'd2;

	localparam logic [7:0]  TYPE_MASK        = 8'h0F;
	localparam logic [7:0]  TYPE_FUNCTION    = 8'h02;
	localparam logic [15:0] NAME_TABLE_RESET = 16'hFFFF;

	localparam int COUNT_OUT_W = 9;

	// request as it travels down the cell row, with its partial result
	typedef struct packed {
		logic                   lookup;
		logic                   wr;
		logic [31:0]            addr;      // pc for lookups, start for loads
		logic [31:0]            end_addr;  // start + size, wrapped
		logic [31:0]            name;
		logic                   hit;
		logic [31:0]            res_start;
		logic [31:0]            res_name;
		logic [COUNT_OUT_W-1:0] stored_count;
		logic                   dropped;
	} item_t;

endpackage

// File: sv/frsl_if.sv
interface frsl_req_if;
	logic        valid;
	logic        ready;
	logic [1:0]  mode;
	logic [31:0] sym_name_off;
	logic [31:0] sym_value;
	logic [31:0] sym_size;
	logic [7:0]  sym_info;
	logic [31:0] pc;

	modport source (output valid, mode, sym_name_off, sym_value, sym_size, sym_info, pc,
		input ready);
	modport sink (input valid, mode, sym_name_off, sym_value, sym_size, sym_info, pc,
		output ready);
endinterface

interface frsl_rsp_if;
	logic        valid;
	logic        ready;
	logic        hit;
	logic [31:0] start_address;
	logic [31:0] func_name;
	logic [8:0]  stored_count;
	logic        dropped;

	modport source (output valid, hit, start_address, func_name, stored_count, dropped,
		input ready);
	modport sink (input valid, hit, start_address, func_name, stored_count, dropped,
		output ready);
endinterface

// File: sv/frsl_cell.sv
module frsl_cell #(
	parameter int IDX = 0,
	parameter int CW  = 9
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 adv,
	input  logic                 vld_in,
	input  frsl_pkg::item_t      item_in,
	input  logic [CW-1:0]        cnt_in,
	output logic                 vld_s1,
	output frsl_pkg::item_t      item_s1,
	output logic [CW-1:0]        cnt_s1
);

	logic [31:0] start_q;
	logic [31:0] end_q;
	logic [31:0] name_q;

	logic            in_range;
	logic            match;
	logic            store;
	frsl_pkg::item_t item_nxt;

	// entry is live for this request only if it sits below the count seen at issue
	assign in_range = cnt_in > CW'(IDX);
	assign match    = item_in.lookup && !item_in.hit && in_range &&
		(item_in.addr >= start_q) && (item_in.addr < end_q);
	assign store    = adv && vld_in && item_in.wr && (cnt_in == CW'(IDX));

	always_comb begin
		item_nxt = item_in;
		if (match) begin
			item_nxt.hit       = 1'b1;
			item_nxt.res_start = start_q;
			item_nxt.res_name  = name_q;
		end
	end

	always_ff @(posedge clk) begin
		if (store) begin
			start_q <= item_in.addr;
			end_q   <= item_in.end_addr;
			name_q  <= item_in.name;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= vld_in;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			item_s1 <= item_nxt;
			cnt_s1  <= cnt_in;
		end
	end

endmodule

// File: sv/function_range_symbol_lookup.sv
// Each accepted request is registered in every one of the MAX_ENTRIES cells before it shows as the response.
// Throughput: one request per cycle while the row advances; it walks the row of MAX_ENTRIES cells, one cell a cycle.
// A stalled response freezes the whole row, and the request port waits with it.
// Reset: entry count 0, name table size 65535, row empty; table contents stay undefined
// (no clearing pass, entries at or above the count are never looked at).
module function_range_symbol_lookup #(
	parameter int MAX_ENTRIES = 256
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [15:0] cfg_wdata,
	frsl_req_if.sink    req,
	frsl_rsp_if.source  rsp
);

	localparam int CW = $clog2(MAX_ENTRIES + 1);

	logic [CW-1:0] count_q;
	logic [CW-1:0] count_nxt;
	logic [15:0]   name_tbl_size_q;

	logic adv;
	logic accept;
	logic qual;
	logic full;
	logic wr;
	logic [CW+frsl_pkg::COUNT_OUT_W-1:0] count_ext;

	logic            chain_vld  [0:MAX_ENTRIES];
	frsl_pkg::item_t chain_item [0:MAX_ENTRIES];
	logic [CW-1:0]   chain_cnt  [0:MAX_ENTRIES];

	assign adv       = !chain_vld[MAX_ENTRIES] || rsp.ready;
	assign accept    = req.valid && adv;
	assign req.ready = adv;

	assign qual = (req.mode == frsl_pkg::MODE_LOAD) &&
		((req.sym_info & frsl_pkg::TYPE_MASK) == frsl_pkg::TYPE_FUNCTION) &&
		(req.sym_name_off < {16'h0000, name_tbl_size_q});
	assign full = count_q == CW'(MAX_ENTRIES);
	assign wr   = qual && !full;

	always_comb begin
		count_nxt = count_q;
		if (req.mode == frsl_pkg::MODE_CLEAR) begin
			count_nxt = '0;
		end else if (wr) begin
			count_nxt = count_q + CW'(1);
		end
	end

	assign count_ext = {{frsl_pkg::COUNT_OUT_W{1'b0}}, count_nxt};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (accept) begin
			count_q <= count_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			name_tbl_size_q <= frsl_pkg::NAME_TABLE_RESET;
		end else if (cfg_we) begin
			name_tbl_size_q <= cfg_wdata;
		end
	end

	// head of the row: count and drop flag are settled here, the search happens in the cells
	always_comb begin
		chain_vld[0]               = req.valid;
		chain_cnt[0]               = count_q;
		chain_item[0].lookup       = req.mode == frsl_pkg::MODE_LOOKUP;
		chain_item[0].wr           = wr;
		chain_item[0].addr         = (req.mode == frsl_pkg::MODE_LOOKUP) ? req.pc : req.sym_value;
		chain_item[0].end_addr     = req.sym_value + req.sym_size;
		chain_item[0].name         = req.sym_name_off;
		chain_item[0].hit          = 1'b0;
		chain_item[0].res_start    = '0;
		chain_item[0].res_name     = '0;
		chain_item[0].stored_count = count_ext[frsl_pkg::COUNT_OUT_W-1:0];
		chain_item[0].dropped      = qual && full;
	end

	for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_cell
		frsl_cell #(
			.IDX (i),
			.CW  (CW)
		) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.adv     (adv),
			.vld_in  (chain_vld[i]),
			.item_in (chain_item[i]),
			.cnt_in  (chain_cnt[i]),
			.vld_s1  (chain_vld[i+1]),
			.item_s1 (chain_item[i+1]),
			.cnt_s1  (chain_cnt[i+1])
		);
	end

	assign rsp.valid         = chain_vld[MAX_ENTRIES];
	assign rsp.hit           = chain_item[MAX_ENTRIES].hit;
	assign rsp.start_address = chain_item[MAX_ENTRIES].res_start;
	assign rsp.func_name     = chain_item[MAX_ENTRIES].res_name;
	assign rsp.stored_count  = chain_item[MAX_ENTRIES].stored_count;
	assign rsp.dropped       = chain_item[MAX_ENTRIES].dropped;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(MAX_ENTRIES))
		else $error("entry count above table size");

	a_stall_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && !rsp.ready |-> !req.ready)
		else $error("request taken while row is stalled");

	a_clear_count: assert property (@(posedge clk) disable iff (!arst_n)
		req.valid && req.ready && req.mode == frsl_pkg::MODE_CLEAR |=> count_q == '0)
		else $error("clear did not empty the table");

	a_hit_not_dropped: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.hit |-> !rsp.dropped && chain_cnt[MAX_ENTRIES] != '0)
		else $error("hit on an empty table or with drop flag");

	a_drop_full: assert property (@(posedge clk) disable iff (!arst_n)
		accept && qual && full |=> count_q == CW'(MAX_ENTRIES))
		else $error("dropped load changed the count");

endmodule
